// ----- rtl/mvt_pkg.sv -----
// mvt_pkg: shared types, widths and constants of the 4x4 matrix-vector transform
// used by the channel interfaces, the lanes, the merge stage and the top level
// no dependencies
package mvt_pkg;

  localparam int unsigned N_LANES   = 4;
  localparam int unsigned ELEM_W    = 16;
  localparam int unsigned ROW_W     = 64;
  localparam int unsigned PROD_W    = 2 * ELEM_W;
  // four products need two bits of growth; the rounding bias fits in that same headroom
  localparam int unsigned SUM_W     = PROD_W + 2;
  localparam int unsigned FRAC_BITS = 12;
  localparam int unsigned RND_W     = SUM_W - FRAC_BITS;

  // apb address: one 64-bit register every 8 bytes
  localparam int unsigned ADDR_W    = 5;
  localparam int unsigned REG_LSB   = 3;

  localparam logic signed [SUM_W-1:0] ROUND_BIAS = 34'sd2048;
  localparam logic signed [RND_W-1:0] SAT_MAX    = 22'sd32767;
  localparam logic signed [RND_W-1:0] SAT_MIN    = -22'sd32768;

  localparam logic signed [ELEM_W-1:0] ELEM_MAX = 16'sh7fff;
  localparam logic signed [ELEM_W-1:0] ELEM_MIN = 16'sh8000;

  // transform forms
  localparam logic OP_COLUMN = 1'b0;
  localparam logic OP_ROW    = 1'b1;

  typedef logic signed [ELEM_W-1:0] elem_t;
  typedef elem_t                    elem_vec_t [N_LANES];
  typedef logic signed [SUM_W-1:0]  sum_t;
  typedef sum_t                     sum_vec_t [N_LANES];
  typedef logic [ROW_W-1:0]         row_t;
  typedef row_t                     matrix_t [N_LANES];
  typedef logic [ADDR_W-REG_LSB-1:0] reg_idx_t;

  // identity matrix, Q3.12 one on the diagonal
  localparam matrix_t MATRIX_RST = '{
    64'h0000_0000_0000_1000,
    64'h0000_0000_1000_0000,
    64'h0000_1000_0000_0000,
    64'h1000_0000_0000_0000
  };

  // load enables of the two lane pipeline stages
  typedef struct packed {
    logic en_mul;
    logic en_sum;
  } lane_ctrl_t;

endpackage

// ----- rtl/mvt_in_if.sv -----
// mvt_in_if: valid/ready channel carrying one input vector and the transform form
// depends on mvt_pkg
interface mvt_in_if;
  logic          valid;
  logic          ready;
  logic          op;
  mvt_pkg::elem_t in_x;
  mvt_pkg::elem_t in_y;
  mvt_pkg::elem_t in_z;
  mvt_pkg::elem_t in_w;

  modport source (output valid, op, in_x, in_y, in_z, in_w, input ready);
  modport sink   (input valid, op, in_x, in_y, in_z, in_w, output ready);
endinterface

// ----- rtl/mvt_out_if.sv -----
// mvt_out_if: valid/ready channel carrying one transformed vector and its clip flag
// depends on mvt_pkg
interface mvt_out_if;
  logic          valid;
  logic          ready;
  mvt_pkg::elem_t out_x;
  mvt_pkg::elem_t out_y;
  mvt_pkg::elem_t out_z;
  mvt_pkg::elem_t out_w;
  logic          saturated;

  modport source (output valid, out_x, out_y, out_z, out_w, saturated, input ready);
  modport sink   (input valid, out_x, out_y, out_z, out_w, saturated, output ready);
endinterface

// ----- rtl/matrix_vector_transform_4x4.sv -----
// matrix_vector_transform_4x4: top level, coefficient selection, four lanes,
// merge stage, pipeline control and the apb matrix registers
// depends on mvt_pkg, mvt_in_if, mvt_out_if, mvt_lane, mvt_merge
//
// usage
//   in_ch  : one transaction carries a Q8.8 vector (in_x..in_w) and op;
//            op 0 sums down the first matrix index (column form),
//            op 1 sums along the second index (row form)
//   out_ch : one transaction per input, four Q8.8 components rounded to
//            nearest (ties upward) and clipped, saturated set on any clip
//   apb    : four 64-bit row registers at byte addresses 0, 8, 16, 24,
//            coefficient j of a row at bits 16j upward, signed Q3.12;
//            pready is tied high, reads return the row, write only when idle
//   timing : three-stage pipeline (products, sum, saturate/output register),
//            each input passing the product, sum and output registers in turn;
//            one transaction per cycle sustained while out_ch.ready is high:
//            sixteen multipliers work in parallel, one stage per operation
//   reset  : synchronous active-low rst_n empties the pipeline and loads the
//            identity matrix
//   stall  : when out_ch.ready is low each stage holds while full, the
//            pipeline keeps filling its bubbles, and in_ch.ready drops only
//            once all three stages hold a transaction
module matrix_vector_transform_4x4 (
  input  logic                         clk,
  input  logic                         rst_n,
  mvt_in_if.sink                       in_ch,
  mvt_out_if.source                    out_ch,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [mvt_pkg::ADDR_W-1:0]   paddr,
  input  logic [mvt_pkg::ROW_W-1:0]    pwdata,
  output logic [mvt_pkg::ROW_W-1:0]    prdata,
  output logic                         pready
);

  // matrix registers
  mvt_pkg::matrix_t  matrix_r;
  mvt_pkg::reg_idx_t reg_idx;
  logic              cfg_wr;

  // pipeline occupancy
  logic v_mul_r;
  logic v_sum_r;
  logic v_out_r;
  logic en_mul;
  logic en_sum;
  logic en_out;

  mvt_pkg::lane_ctrl_t lane_ctrl;
  mvt_pkg::elem_vec_t  vec;
  mvt_pkg::elem_vec_t  coef_sel [mvt_pkg::N_LANES];
  mvt_pkg::sum_vec_t   sums;
  mvt_pkg::elem_vec_t  res;
  logic                res_sat;

  // apb: register at 8*i, low address bits ignored
  assign reg_idx = paddr[mvt_pkg::ADDR_W-1:mvt_pkg::REG_LSB];
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign pready  = 1'b1;
  assign prdata  = matrix_r[reg_idx];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      matrix_r <= mvt_pkg::MATRIX_RST;
    end else if (cfg_wr) begin
      matrix_r[reg_idx] <= pwdata;
    end
  end

  // a stage loads when empty or when the stage after it moves on
  assign en_out      = ~v_out_r | out_ch.ready;
  assign en_sum      = ~v_sum_r | en_out;
  assign en_mul      = ~v_mul_r | en_sum;
  assign in_ch.ready = en_mul;

  assign lane_ctrl.en_mul = en_mul;
  assign lane_ctrl.en_sum = en_sum;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_mul_r <= 1'b0;
      v_sum_r <= 1'b0;
      v_out_r <= 1'b0;
    end else begin
      if (en_mul) begin
        v_mul_r <= in_ch.valid;
      end
      if (en_sum) begin
        v_sum_r <= v_mul_r;
      end
      if (en_out) begin
        v_out_r <= v_sum_r;
      end
    end
  end

  assign vec[0] = in_ch.in_x;
  assign vec[1] = in_ch.in_y;
  assign vec[2] = in_ch.in_z;
  assign vec[3] = in_ch.in_w;

  // lane k, term n: row form takes e(k,n), column form takes e(n,k)
  always_comb begin
    for (int k = 0; k < mvt_pkg::N_LANES; k++) begin
      for (int n = 0; n < mvt_pkg::N_LANES; n++) begin
        unique case (in_ch.op)
          mvt_pkg::OP_ROW:
            coef_sel[k][n] = matrix_r[k][n*mvt_pkg::ELEM_W +: mvt_pkg::ELEM_W];
          default:
            coef_sel[k][n] = matrix_r[n][k*mvt_pkg::ELEM_W +: mvt_pkg::ELEM_W];
        endcase
      end
    end
  end

  for (genvar k = 0; k < mvt_pkg::N_LANES; k++) begin : g_lane
    mvt_lane u_lane (
      .clk   (clk),
      .ctrl  (lane_ctrl),
      .coef  (coef_sel[k]),
      .vec   (vec),
      .sum_o (sums[k])
    );
  end

  mvt_merge u_merge (
    .clk       (clk),
    .en        (en_out),
    .sums      (sums),
    .res       (res),
    .saturated (res_sat)
  );

  assign out_ch.valid     = v_out_r;
  assign out_ch.out_x     = res[0];
  assign out_ch.out_y     = res[1];
  assign out_ch.out_z     = res[2];
  assign out_ch.out_w     = res[3];
  assign out_ch.saturated = res_sat;

endmodule

// ----- rtl/mvt_lane.sv -----
// mvt_lane: one output component, four registered products then a registered biased sum
// depends on mvt_pkg
module mvt_lane (
  input  logic                clk,
  input  mvt_pkg::lane_ctrl_t ctrl,
  input  mvt_pkg::elem_vec_t  coef,
  input  mvt_pkg::elem_vec_t  vec,
  output mvt_pkg::sum_t       sum_o
);

  logic signed [mvt_pkg::PROD_W-1:0] prod_r   [mvt_pkg::N_LANES];
  logic signed [mvt_pkg::PROD_W-1:0] prod_nxt [mvt_pkg::N_LANES];
  mvt_pkg::sum_t                     sum_r;
  mvt_pkg::sum_t                     sum_nxt;

  always_comb begin
    for (int i = 0; i < mvt_pkg::N_LANES; i++) begin
      prod_nxt[i] = coef[i] * vec[i];
    end
  end

  // bias included so the merge stage only has to shift
  always_comb begin
    sum_nxt = mvt_pkg::ROUND_BIAS;
    for (int i = 0; i < mvt_pkg::N_LANES; i++) begin
      sum_nxt = sum_nxt + mvt_pkg::SUM_W'(prod_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.en_mul) begin
      prod_r <= prod_nxt;
    end
    if (ctrl.en_sum) begin
      sum_r <= sum_nxt;
    end
  end

  assign sum_o = sum_r;

endmodule

// ----- rtl/mvt_merge.sv -----
// mvt_merge: shifts and saturates the four lane sums, gathers the clip flags
// into the output register; depends on mvt_pkg
module mvt_merge (
  input  logic               clk,
  input  logic               en,
  input  mvt_pkg::sum_vec_t  sums,
  output mvt_pkg::elem_vec_t res,
  output logic               saturated
);

  mvt_pkg::elem_vec_t res_r;
  mvt_pkg::elem_vec_t res_nxt;
  logic               sat_r;
  logic               sat_nxt;
  logic signed [mvt_pkg::RND_W-1:0] rnd [mvt_pkg::N_LANES];

  always_comb begin
    sat_nxt = 1'b0;
    for (int i = 0; i < mvt_pkg::N_LANES; i++) begin
      rnd[i] = sums[i][mvt_pkg::SUM_W-1:mvt_pkg::FRAC_BITS];
      if (rnd[i] > mvt_pkg::SAT_MAX) begin
        res_nxt[i] = mvt_pkg::ELEM_MAX;
        sat_nxt    = 1'b1;
      end else if (rnd[i] < mvt_pkg::SAT_MIN) begin
        res_nxt[i] = mvt_pkg::ELEM_MIN;
        sat_nxt    = 1'b1;
      end else begin
        res_nxt[i] = rnd[i][mvt_pkg::ELEM_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
      sat_r <= sat_nxt;
    end
  end

  assign res       = res_r;
  assign saturated = sat_r;

endmodule

// ----- tb/tb_top.sv -----
// tb_top: self-checking bench for matrix_vector_transform_4x4, with its own fixed-point predictor
// and random stalls on both channels; matrices are loaded over the apb port before each block
// depends on mvt_pkg, mvt_in_if, mvt_out_if and the matrix_vector_transform_4x4 rtl
module tb_top;

  localparam int unsigned CLK_HALF     = 5;
  localparam int unsigned RESET_CYCLES = 7;
  // cycles with no transaction on any channel and no apb access before the run is abandoned
  localparam int unsigned STALL_LIMIT  = 5000;
  // settle time once nothing is expected, well beyond the three pipeline stages
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned BLOCK_ITEMS  = 75;
  localparam int unsigned N_BLOCKS     = 3;
  localparam int unsigned N_PHASES     = 4;

  // apb register indexes
  localparam mvt_pkg::reg_idx_t REG_MATRIX_ROW_0 = 2'd0;
  localparam mvt_pkg::reg_idx_t REG_MATRIX_ROW_1 = 2'd1;
  localparam mvt_pkg::reg_idx_t REG_MATRIX_ROW_2 = 2'd2;
  localparam mvt_pkg::reg_idx_t REG_MATRIX_ROW_3 = 2'd3;

  // half coefficients on rows 0 and 2 give rounding ties, row 1 has tiny values, row 3 extremes
  localparam mvt_pkg::matrix_t MATRIX_TIE = '{
    64'h0800_0800_0800_0800,
    64'h0004_0003_0002_0001,
    64'h0800_f800_0800_f800,
    64'h1000_0000_8000_7fff
  };
  localparam mvt_pkg::matrix_t MATRIX_ALL_MAX = '{4{64'h7fff_7fff_7fff_7fff}};
  localparam mvt_pkg::matrix_t MATRIX_ALL_MIN = '{4{64'h8000_8000_8000_8000}};

  typedef struct packed {
    logic           op;
    mvt_pkg::elem_t x;
    mvt_pkg::elem_t y;
    mvt_pkg::elem_t z;
    mvt_pkg::elem_t w;
  } vec_item_t;

  typedef struct packed {
    mvt_pkg::elem_t x;
    mvt_pkg::elem_t y;
    mvt_pkg::elem_t z;
    mvt_pkg::elem_t w;
    logic           sat;
  } xform_res_t;

  logic                          clk     = 1'b0;
  logic                          rst_n   = 1'b0;
  logic                          psel    = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite  = 1'b0;
  logic [mvt_pkg::ADDR_W-1:0]    paddr   = '0;
  logic [mvt_pkg::ROW_W-1:0]     pwdata  = '0;
  logic [mvt_pkg::ROW_W-1:0]     prdata;
  logic                          pready;

  mvt_in_if  in_ch ();
  mvt_out_if out_ch ();

  // predictor copy of the row registers
  mvt_pkg::matrix_t     coef_rows;
  vec_item_t            pending_vecs [$];
  xform_res_t           expected_vecs [$];
  vec_item_t            drive_vec;
  xform_res_t           exp_res;
  int unsigned          send_idle_pct  = 0;
  int unsigned          recv_stall_pct = 0;
  logic                 hold_send      = 1'b0;
  int unsigned          idle_cycles    = 0;
  int unsigned          err_count      = 0;

  matrix_vector_transform_4x4 i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #CLK_HALF clk = ~clk;

  // expected transform of one vector: four sums of products, round half up, clip
  function automatic xform_res_t transform_vec(input mvt_pkg::matrix_t m, input vec_item_t it);
    mvt_pkg::elem_t v [mvt_pkg::N_LANES];
    mvt_pkg::elem_t r [mvt_pkg::N_LANES];
    mvt_pkg::elem_t c;
    longint         acc;
    longint         q;
    logic           clip;
    xform_res_t     res;
    v[0] = it.x;
    v[1] = it.y;
    v[2] = it.z;
    v[3] = it.w;
    clip = 1'b0;
    for (int k = 0; k < mvt_pkg::N_LANES; k++) begin
      acc = 0;
      for (int n = 0; n < mvt_pkg::N_LANES; n++) begin
        // row form walks along row k, column form down column k
        if (it.op == mvt_pkg::OP_ROW) begin
          c = m[k][mvt_pkg::ELEM_W*n +: mvt_pkg::ELEM_W];
        end else begin
          c = m[n][mvt_pkg::ELEM_W*k +: mvt_pkg::ELEM_W];
        end
        acc += longint'(c) * longint'(v[n]);
      end
      // floor shift after the bias, so ties go towards plus infinity
      q = (acc + longint'(mvt_pkg::ROUND_BIAS)) >>> mvt_pkg::FRAC_BITS;
      if (q > longint'(mvt_pkg::SAT_MAX)) begin
        q    = longint'(mvt_pkg::SAT_MAX);
        clip = 1'b1;
      end else if (q < longint'(mvt_pkg::SAT_MIN)) begin
        q    = longint'(mvt_pkg::SAT_MIN);
        clip = 1'b1;
      end
      r[k] = q[mvt_pkg::ELEM_W-1:0];
    end
    res.x   = r[0];
    res.y   = r[1];
    res.z   = r[2];
    res.w   = r[3];
    res.sat = clip;
    return res;
  endfunction

  // vector components: full range half the time, with extremes and small values mixed in
  function automatic mvt_pkg::elem_t rand_elem();
    case ($urandom_range(9))
      0:       return mvt_pkg::ELEM_MAX;
      1:       return mvt_pkg::ELEM_MIN;
      2:       return $urandom_range(1) ? mvt_pkg::elem_t'(-1) : mvt_pkg::elem_t'(0);
      3, 4:    return mvt_pkg::elem_t'($urandom_range(1024) - 512);
      default: return mvt_pkg::elem_t'($urandom);
    endcase
  endfunction

  // coefficients: extremes, zero, full range, and values between minus one and one
  function automatic mvt_pkg::elem_t rand_coef();
    case ($urandom_range(9))
      0:       return mvt_pkg::ELEM_MAX;
      1:       return mvt_pkg::ELEM_MIN;
      2:       return mvt_pkg::elem_t'(0);
      3, 4, 5: return mvt_pkg::elem_t'($urandom);
      default: return mvt_pkg::elem_t'($urandom_range(8192) - 4096);
    endcase
  endfunction

  function automatic mvt_pkg::matrix_t rand_matrix();
    mvt_pkg::matrix_t m;
    for (int i = 0; i < mvt_pkg::N_LANES; i++) begin
      for (int j = 0; j < mvt_pkg::N_LANES; j++) begin
        m[i][mvt_pkg::ELEM_W*j +: mvt_pkg::ELEM_W] = rand_coef();
      end
    end
    return m;
  endfunction

  function automatic vec_item_t rand_vec();
    vec_item_t it;
    it.op = ($urandom_range(1) == 0) ? mvt_pkg::OP_COLUMN : mvt_pkg::OP_ROW;
    it.x  = rand_elem();
    it.y  = rand_elem();
    it.z  = rand_elem();
    it.w  = rand_elem();
    return it;
  endfunction

  function automatic void push_vec(input logic op, input mvt_pkg::elem_t x,
                                   input mvt_pkg::elem_t y, input mvt_pkg::elem_t z,
                                   input mvt_pkg::elem_t w);
    pending_vecs.push_back('{op: op, x: x, y: y, z: z, w: w});
  endfunction

  // apb write: setup cycle, then access cycle; the register loads at the closing edge
  task automatic apb_write(input mvt_pkg::reg_idx_t idx, input mvt_pkg::row_t data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= mvt_pkg::ADDR_W'(idx) << mvt_pkg::REG_LSB;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    coef_rows[idx] = data;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic load_matrix(input mvt_pkg::matrix_t m);
    apb_write(REG_MATRIX_ROW_0, m[0]);
    apb_write(REG_MATRIX_ROW_1, m[1]);
    apb_write(REG_MATRIX_ROW_2, m[2]);
    apb_write(REG_MATRIX_ROW_3, m[3]);
    @(negedge clk);
  endtask

  // block idle: everything sent, every result back, pipeline settled
  task automatic drain_pipeline();
    while (pending_vecs.size() != 0 || in_ch.valid || expected_vecs.size() != 0) begin
      @(negedge clk);
    end
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // driver: predicts on each accepted input transaction, then offers the next one
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_vecs.push_back(transform_vec(coef_rows,
          vec_item_t'({in_ch.op, in_ch.in_x, in_ch.in_y, in_ch.in_z, in_ch.in_w})));
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_vecs.size() != 0 && !hold_send &&
            $urandom_range(99) >= send_idle_pct) begin
          drive_vec   = pending_vecs.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.op    <= drive_vec.op;
          in_ch.in_x  <= drive_vec.x;
          in_ch.in_y  <= drive_vec.y;
          in_ch.in_z  <= drive_vec.z;
          in_ch.in_w  <= drive_vec.w;
        end else begin
          // idle cycle: junk on the payload, it must be ignored
          in_ch.valid <= 1'b0;
          in_ch.op    <= 1'($urandom);
          in_ch.in_x  <= mvt_pkg::elem_t'($urandom);
          in_ch.in_y  <= mvt_pkg::elem_t'($urandom);
          in_ch.in_z  <= mvt_pkg::elem_t'($urandom);
          in_ch.in_w  <= mvt_pkg::elem_t'($urandom);
        end
      end
    end
  end

  // monitor: each result transaction against the oldest prediction, then random back-pressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_vecs.size() == 0) begin
          $error("result transaction with no prediction waiting");
          err_count++;
        end else begin
          exp_res = expected_vecs.pop_front();
          if (out_ch.out_x !== exp_res.x) begin
            $error("out_x: expected %0d, got %0d", exp_res.x, out_ch.out_x);
            err_count++;
          end
          if (out_ch.out_y !== exp_res.y) begin
            $error("out_y: expected %0d, got %0d", exp_res.y, out_ch.out_y);
            err_count++;
          end
          if (out_ch.out_z !== exp_res.z) begin
            $error("out_z: expected %0d, got %0d", exp_res.z, out_ch.out_z);
            err_count++;
          end
          if (out_ch.out_w !== exp_res.w) begin
            $error("out_w: expected %0d, got %0d", exp_res.w, out_ch.out_w);
            err_count++;
          end
          if (out_ch.saturated !== exp_res.sat) begin
            $error("saturated: expected %0d, got %0d", exp_res.sat, out_ch.saturated);
            err_count++;
          end
        end
      end
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // watchdog: any transaction or apb activity restarts the count
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("tb_top: errors");
        $finish;
      end
    end
  end

  initial begin
    // known levels on every input from time zero
    in_ch.valid  = 1'b0;
    in_ch.op     = mvt_pkg::OP_COLUMN;
    in_ch.in_x   = '0;
    in_ch.in_y   = '0;
    in_ch.in_z   = '0;
    in_ch.in_w   = '0;
    out_ch.ready = 1'b0;
    coef_rows    = mvt_pkg::MATRIX_RST;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // identity after reset: zero, field extremes, both forms
    push_vec(mvt_pkg::OP_COLUMN, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000);
    push_vec(mvt_pkg::OP_ROW, mvt_pkg::ELEM_MAX, mvt_pkg::ELEM_MIN, 16'sh0001, -16'sh0001);
    push_vec(mvt_pkg::OP_COLUMN, mvt_pkg::ELEM_MIN, mvt_pkg::ELEM_MAX, -16'sh0001, 16'sh0001);
    push_vec(mvt_pkg::OP_ROW,    16'sh5555, 16'shaaaa, 16'sh00ff, 16'shff00);
    push_vec(mvt_pkg::OP_COLUMN, 16'shaaaa, 16'sh5555, 16'shff00, 16'sh00ff);
    drain_pipeline();

    // half coefficients: odd sums land exactly on a tie, positive and negative
    load_matrix(MATRIX_TIE);
    push_vec(mvt_pkg::OP_COLUMN, 16'sh0001,  16'sh0000, 16'sh0000, 16'sh0000);
    push_vec(mvt_pkg::OP_COLUMN, -16'sh0001, 16'sh0000, 16'sh0000, 16'sh0000);
    push_vec(mvt_pkg::OP_COLUMN, 16'sh0003,  16'sh0000, 16'sh0000, 16'sh0000);
    push_vec(mvt_pkg::OP_COLUMN, -16'sh0003, 16'sh0000, 16'sh0000, 16'sh0000);
    push_vec(mvt_pkg::OP_ROW,    16'sh0001,  16'sh0002, -16'sh0003, 16'sh0004);
    push_vec(mvt_pkg::OP_ROW, mvt_pkg::ELEM_MIN, mvt_pkg::ELEM_MAX,
             mvt_pkg::ELEM_MIN, mvt_pkg::ELEM_MAX);
    drain_pipeline();

    // largest coefficients: clipping towards both limits
    load_matrix(MATRIX_ALL_MAX);
    push_vec(mvt_pkg::OP_COLUMN, mvt_pkg::ELEM_MAX, mvt_pkg::ELEM_MAX,
             mvt_pkg::ELEM_MAX, mvt_pkg::ELEM_MAX);
    push_vec(mvt_pkg::OP_ROW, mvt_pkg::ELEM_MIN, mvt_pkg::ELEM_MIN,
             mvt_pkg::ELEM_MIN, mvt_pkg::ELEM_MIN);
    push_vec(mvt_pkg::OP_COLUMN, mvt_pkg::ELEM_MAX, mvt_pkg::ELEM_MIN,
             mvt_pkg::ELEM_MAX, mvt_pkg::ELEM_MIN);
    push_vec(mvt_pkg::OP_ROW, 16'sh0001, 16'sh0000, 16'sh0000, 16'sh0000);
    drain_pipeline();

    // most negative coefficients: largest positive sum of the block
    load_matrix(MATRIX_ALL_MIN);
    push_vec(mvt_pkg::OP_COLUMN, mvt_pkg::ELEM_MIN, mvt_pkg::ELEM_MIN,
             mvt_pkg::ELEM_MIN, mvt_pkg::ELEM_MIN);
    push_vec(mvt_pkg::OP_ROW, mvt_pkg::ELEM_MAX, mvt_pkg::ELEM_MAX,
             mvt_pkg::ELEM_MAX, mvt_pkg::ELEM_MAX);
    push_vec(mvt_pkg::OP_COLUMN, mvt_pkg::ELEM_MIN, mvt_pkg::ELEM_MAX,
             mvt_pkg::ELEM_MIN, mvt_pkg::ELEM_MAX);
    push_vec(mvt_pkg::OP_ROW, -16'sh0001, 16'sh0000, 16'sh0000, 16'sh0000);

    // random part: one idling pattern per phase, a fresh matrix per block
    for (int ph = 0; ph < N_PHASES; ph++) begin
      case (ph)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 59;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 59;
        end
        default: begin
          send_idle_pct  = 23;
          recv_stall_pct = 23;
        end
      endcase
      for (int blk = 0; blk < N_BLOCKS; blk++) begin
        drain_pipeline();
        load_matrix(rand_matrix());
        repeat (BLOCK_ITEMS) pending_vecs.push_back(rand_vec());
        if (ph == 1 && blk == 1) begin
          // sender holds off mid-block until the pipeline has emptied
          while (pending_vecs.size() > BLOCK_ITEMS / 2) @(negedge clk);
          hold_send = 1'b1;
          while (in_ch.valid || expected_vecs.size() != 0) @(negedge clk);
          hold_send = 1'b0;
        end
      end
    end

    drain_pipeline();
    if (err_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
